// ===== rtl/core/double_ended_queue_indexed_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed double-ended queue
// Shared wrappers for concurrent checks clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_INDEXED_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_INDEXED_TOP_ASSERT_SVH

// Same-cycle implication check.
`define DQI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqi assertion failed");

// Next-cycle implication check.
`define DQI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqi assertion failed");

`endif

// ===== rtl/core/dqi_pkg.sv =====
// ----------------------------------------------------------------------------
// dqi_pkg
// Shared codes, defaults and control types of the indexed double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dqi_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_READ_AT    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_out;
  } dqi_ctl_t;

  typedef struct packed {
    logic out_valid;
  } dqi_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue_indexed_top.sv =====
// ----------------------------------------------------------------------------
// Indexed double-ended queue
// Usage: each request on the in_ stream is one command (push front, push
// back, pop front, pop back, or read at a position counted from the front).
// Every request yields exactly one result on the out_ stream carrying a
// status, the popped or read word, and the number of entries held after it.
// The block takes no new request until the last one has moved its result
// to the output register: the ring store is read through a registered
// port, so a request first does the store access into the read and pending
// registers, then moves its result to the output register.
// The output register is separate from the command path, so the next
// request is accepted while a result waits; if the receiver stalls longer,
// the block holds the following result and deasserts in_tready.
// Reset empties the queue and the output; the store needs no clearing pass,
// since only entries inside the count are ever read.
// Unused command codes return success with the count unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_indexed_top_assert.svh"

module double_ended_queue_indexed_top
  import dqi_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // cmd[2:0], push_value[34:3], position[42:35]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // status[1:0], data_out[33:2], occupancy[42:34]
);

  dqi_ctl_t    ctl;
  dqi_stat_t   stat;
  logic [1:0]  res_status;
  logic [31:0] res_data;
  logic [8:0]  res_occ;

  dqi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  dqi_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_cmd        (in_tdata[2:0]),
    .in_push_value (in_tdata[34:3]),
    .in_position   (in_tdata[42:35]),
    .out_tready    (out_tready),
    .stat          (stat),
    .out_tvalid    (out_tvalid),
    .out_status    (res_status),
    .out_data      (res_data),
    .out_occupancy (res_occ)
  );

  assign out_tdata = {5'd0, res_occ, res_data, res_status};

  `DQI_ASSERT_NXT(a_one_request_in_flight, in_tvalid && in_tready, !in_tready)
  `DQI_ASSERT_IMP(a_fail_has_no_data, out_tvalid && (out_tdata[1:0] != ST_OK),
                  out_tdata[33:2] == 32'd0)
  `DQI_ASSERT_NXT(a_result_follows_request, in_tvalid && in_tready && !out_tvalid,
                  !in_tready ##1 out_tvalid)

endmodule

`default_nettype wire

// ===== rtl/core/dqi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqi_ctrl
// Command sequencer: takes a request, waits for the store read, then hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dqi_ctrl
  import dqi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      out_tready,
  input  wire dqi_stat_t stat,
  output dqi_ctl_t       ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_tready    = (state_r == S_IDLE);
  assign ctl.accept   = in_tvalid && in_tready;
  assign ctl.load_out = (state_r == S_EXEC) && (!stat.out_valid || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ctl.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dqi_datapath.sv =====
// ----------------------------------------------------------------------------
// dqi_datapath
// Ring store, front pointer, entry count, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqi_datapath
  import dqi_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dqi_ctl_t    ctl,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_push_value,
  input  wire logic [7:0]  in_position,
  input  wire logic        out_tready,
  output dqi_stat_t        stat,
  output logic             out_tvalid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data,
  output logic [8:0]       out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [PW:0]   DEPTH_S  = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [1:0]            pend_status_r, pend_status_nxt;
  logic                  pend_hit_r, pend_hit_nxt;
  logic [8:0]            pend_occ_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [31:0]           out_data_r;
  logic [8:0]            out_occ_r;

  logic                  full, empty, pos_ok;
  logic [AW-1:0]         front_dec;
  logic [CW-1:0]         count_m1;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [63:0]    rd_ext;

  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [PW-1:0] off);
    logic [PW:0] s;
    s = (PW + 1)'(base) + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);
  assign pos_ok    = (PW'(in_position) < PW'(count_r));
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign count_m1  = count_r - 1'b1;
  assign wdata     = DATA_WIDTH'({32'd0, in_push_value});

  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    we              = 1'b0;
    waddr           = front_dec;
    raddr           = front_r;
    pend_status_nxt = ST_OK;
    pend_hit_nxt    = 1'b0;
    unique case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          pend_status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          waddr     = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          pend_status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          waddr     = slot_at(front_r, PW'(count_r));
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          pend_status_nxt = ST_EMPTY;
        end else begin
          raddr        = front_r;
          pend_hit_nxt = 1'b1;
          front_nxt    = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
          count_nxt    = count_m1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          pend_status_nxt = ST_EMPTY;
        end else begin
          raddr        = slot_at(front_r, PW'(count_m1));
          pend_hit_nxt = 1'b1;
          count_nxt    = count_m1;
        end
      end
      CMD_READ_AT: begin
        if (!pos_ok) begin
          pend_status_nxt = ST_EMPTY;
        end else begin
          raddr        = slot_at(front_r, PW'(in_position));
          pend_hit_nxt = 1'b1;
        end
      end
      default: begin
        pend_status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.accept) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      pend_status_r <= pend_status_nxt;
      pend_hit_r    <= pend_hit_nxt;
      pend_occ_r    <= 9'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (ctl.accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  assign rd_s   = signed'(rdata_r);
  assign rd_ext = 64'(rd_s);

  assign out_valid_nxt = ctl.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_hit_r ? rd_ext[31:0] : 32'd0;
      out_occ_r    <= pend_occ_r;
    end
  end

  assign stat.out_valid = out_valid_r;
  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data       = out_data_r;
  assign out_occupancy  = out_occ_r;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the indexed double-ended queue
// Sends directed and random command requests and predicts each result from a
// behavioral ring model. Both stream sides idle and stall at random. Every
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import dqi_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTS  = 50;

  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [7:0]  position;
    int          idle_before;
    bit          hold_until_drained;
  } dq_request_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] word;
    logic [8:0]  occupancy;
  } dq_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  dq_request_t pending_requests[$];
  dq_result_t  expected_results[$];
  dq_request_t active_request;

  logic [DATA_WIDTH-1:0] ring_model [DEPTH];
  int model_front;
  int model_count;

  int plan_count;
  int plan_len;
  bit plan_idle;
  bit pause_next;

  int error_count;
  int sent_count;
  int total_requests;
  int seen_results;
  int idle_left;
  int stall_left;
  int rx_cycles;
  int cycle_count;
  int n_pushed;
  int n_popped;
  int n_read;
  int n_full_drops;
  int n_empty_reports;
  int peak_occupancy;

  always #5 clk = ~clk;

  double_ended_queue_indexed_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic dq_result_t dq_predict(dq_request_t r);
    dq_result_t res;
    logic signed [DATA_WIDTH-1:0] held;
    int slot;
    res.status = ST_OK;
    res.word   = '0;
    slot       = 0;
    case (r.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
          n_full_drops++;
        end else begin
          if (r.cmd == CMD_PUSH_FRONT) begin
            model_front = (model_front + DEPTH - 1) % DEPTH;
            slot = model_front;
          end else begin
            slot = (model_front + model_count) % DEPTH;
          end
          ring_model[slot] = DATA_WIDTH'(r.value);
          model_count++;
          n_pushed++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
          n_empty_reports++;
        end else begin
          if (r.cmd == CMD_POP_FRONT) begin
            slot = model_front;
            model_front = (model_front + 1) % DEPTH;
          end else begin
            slot = (model_front + model_count - 1) % DEPTH;
          end
          held = ring_model[slot];
          res.word = 32'(held);
          model_count--;
          n_popped++;
        end
      end
      CMD_READ_AT: begin
        if (r.position >= model_count) begin
          res.status = ST_EMPTY;
          n_empty_reports++;
        end else begin
          held = ring_model[(model_front + r.position) % DEPTH];
          res.word = 32'(held);
          n_read++;
        end
      end
      default: ;
    endcase
    res.occupancy = 9'(model_count);
    if (model_count > peak_occupancy) peak_occupancy = model_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH at result %0d, %s: got %h, expected %h",
               seen_results, what, got, want);
  endtask

  task automatic plan(input logic [2:0] cmd, input logic [31:0] value,
                      input logic [7:0] pos);
    dq_request_t r;
    if (plan_len == 0) begin
      plan_idle = ($urandom_range(0, 2) != 0);
      plan_len  = $urandom_range(20, 60);
    end
    plan_len--;
    r.cmd                = cmd;
    r.value              = value;
    r.position           = pos;
    r.hold_until_drained = pause_next;
    r.idle_before        = plan_idle ? draw_gap() : 0;
    pause_next           = 1'b0;
    pending_requests.insert(pending_requests.size(), r);
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
      CMD_POP_FRONT, CMD_POP_BACK:   if (plan_count > 0) plan_count--;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_position();
    if (plan_count > 0 && $urandom_range(0, 4) != 0)
      return 8'($urandom_range(0, plan_count - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic plan_random(input int push_pct, input int pop_pct, input int read_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      plan($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom, 8'($urandom));
    else if (roll < push_pct + pop_pct)
      plan($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom, 8'($urandom));
    else if (roll < push_pct + pop_pct + read_pct)
      plan(CMD_READ_AT, $urandom, pick_position());
    else
      plan(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(), dq_predict(active_request));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 1'b0;
        end else if (pending_requests[0].hold_until_drained &&
                     expected_results.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          active_request = pending_requests[0];
          pending_requests.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, active_request.position, active_request.value,
                        active_request.cmd};
          idle_left = (pending_requests.size() != 0) ? pending_requests[0].idle_before : 0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    dq_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", out_tdata[33:2], '0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_tdata[1:0] != want.status)
            report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
          if (out_tdata[33:2] != want.word)
            report_mismatch("data", out_tdata[33:2], want.word);
          if (out_tdata[42:34] != want.occupancy)
            report_mismatch("occupancy", 32'(out_tdata[42:34]), 32'(want.occupancy));
        end
      end
      rx_cycles++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ((rx_cycles / 400) % 3 != 0 && $urandom_range(0, 3) == 0)
          stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    model_front = 0;
    model_count = 0;
    plan_count  = 0;
    plan_len    = 0;
    pause_next  = 1'b0;
    idle_left   = 0;
    stall_left  = 0;

    // Requests against an empty queue.
    plan(CMD_POP_FRONT, 32'h1234_5678, 8'd0);
    plan(CMD_POP_BACK, 32'h8765_4321, 8'd0);
    plan(CMD_READ_AT, 32'h0, 8'd0);
    plan(CMD_READ_AT, 32'hFFFF_FFFF, 8'd255);
    plan(CMD_UNUSED_LO, 32'hFFFF_FFFF, 8'hFF);
    plan(CMD_UNUSED_MID, 32'hA5A5_5A5A, 8'h5A);
    plan(CMD_UNUSED_HI, 32'h0, 8'h00);
    // Extreme words from both ends.
    plan(CMD_PUSH_FRONT, 32'h8000_0000, 8'hFF);
    plan(CMD_PUSH_BACK, 32'h7FFF_FFFF, 8'h00);
    plan(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'hAA);
    plan(CMD_PUSH_BACK, 32'h0000_0000, 8'h55);
    plan(CMD_PUSH_FRONT, 32'h0000_0001, 8'h01);
    plan(CMD_READ_AT, 32'hFFFF_FFFF, 8'd0);
    plan(CMD_READ_AT, 32'h0, 8'd4);
    plan(CMD_READ_AT, 32'h0, 8'd5);
    plan(CMD_READ_AT, 32'h0, 8'd255);
    plan(CMD_READ_AT, 32'h0, 8'd2);
    plan(CMD_UNUSED_HI, 32'h5555_AAAA, 8'h80);
    plan(CMD_POP_BACK, 32'hFFFF_FFFF, 8'h7F);
    plan(CMD_POP_FRONT, 32'h0, 8'h00);
    plan(CMD_READ_AT, 32'h0, 8'd1);

    pause_next = 1'b1;
    for (i = 0; i < 150; i++) plan_random(40, 30, 25);

    // Fill to capacity, then push into the full queue.
    pause_next = 1'b1;
    while (plan_count < DEPTH) plan_random(85, 0, 15);
    for (i = 0; i < 4; i++)
      plan($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom, 8'($urandom));
    plan(CMD_READ_AT, $urandom, 8'd255);
    plan(CMD_READ_AT, $urandom, 8'd0);
    for (i = 0; i < 6; i++) plan(CMD_READ_AT, $urandom, pick_position());

    // Drain to empty, then pop from the empty queue.
    pause_next = 1'b1;
    while (plan_count > 0) plan_random(0, 85, 15);
    for (i = 0; i < 3; i++)
      plan($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom, 8'($urandom));

    while (pending_requests.size() < 820) plan_random(40, 35, 20);
    total_requests = pending_requests.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_requests || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d words stored, %0d popped, %0d read by position.",
             sent_count, n_pushed, n_popped, n_read);
    $display("Dropped on full: %0d, empty or out-of-range: %0d, peak occupancy: %0d.",
             n_full_drops, n_empty_reports, peak_occupancy);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
